@@ rtl/core/stlw_pkg.sv @@
// Shared types, widths, register indexes and reset values for the saber touch core.
`timescale 1ns / 1ps

package stlw_pkg;

   localparam int TIME_W    = 32;
   localparam int LOCKOUT_W = 22;
   localparam int WINDOW_W  = 17;
   localparam int COUNT_W   = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = LOCKOUT_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_US  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPRESS_US  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WO_BAR_US   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WO_TMO_US   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTR    = 3'd4;

   // register reset values
   localparam logic [LOCKOUT_W-1:0] LOCKOUT_US_RST = 22'd170000;
   localparam logic [WINDOW_W-1:0]  DEPRESS_US_RST = 17'd100;
   localparam logic [WINDOW_W-1:0]  WO_BAR_US_RST  = 17'd4000;
   localparam logic [WINDOW_W-1:0]  WO_TMO_US_RST  = 17'd15000;
   localparam logic [COUNT_W-1:0]   MAX_INTR_RST   = 8'd10;

   localparam logic [COUNT_W-1:0]   COUNT_MAX      = {COUNT_W{1'b1}};

   // word kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef struct packed {
      logic [LOCKOUT_W-1:0] lockout_us;
      logic [WINDOW_W-1:0]  depress_us;
      logic [WINDOW_W-1:0]  wo_bar_us;
      logic [WINDOW_W-1:0]  wo_tmo_us;
      logic [COUNT_W-1:0]   max_intr;
   } cfg_type;

   typedef struct packed {
      logic blade;
      logic target;
      logic self_touch;
   } lines_type;

   typedef struct packed {
      logic lock_req;      // registered touch whose depress began at least the lockout time ago
      logic touch_cur;     // touch flag before this sample
      logic scored;        // touch flag after this sample
      logic self_level;
      logic self_changed;
   } fencer_status_type;

endpackage

@@ rtl/core/stlw_fencer.sv @@
// Per-fencer whipover, depress qualification and self-contact state.
`timescale 1ns / 1ps

module stlw_fencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              sample_en,
   input  logic                              clear_en,
   input  logic [stlw_pkg::TIME_W-1:0]       now,
   input  stlw_pkg::lines_type               lines,
   input  stlw_pkg::cfg_type                 cfg,
   output stlw_pkg::fencer_status_type       status
);

   logic                          touch_ff, touch_in;
   logic [stlw_pkg::TIME_W-1:0]   depress_start_ff, depress_start_in;
   logic                          held_ff, held_in;
   logic                          wo_active_ff, wo_active_in;
   logic [stlw_pkg::TIME_W-1:0]   wo_start_ff, wo_start_in;
   logic [stlw_pkg::COUNT_W-1:0]  intr_cnt_ff, intr_cnt_in;
   logic                          blades_ff, blades_in;
   logic                          permit_ff, permit_in;
   logic                          self_ff, self_in;

   logic [stlw_pkg::TIME_W-1:0]   wo_elapsed;
   logic [stlw_pkg::TIME_W-1:0]   press_elapsed;

   assign wo_elapsed    = now - wo_start_ff;
   assign press_elapsed = now - depress_start_ff;

   always_comb begin
      touch_in         = touch_ff;
      depress_start_in = depress_start_ff;
      held_in          = held_ff;
      wo_active_in     = wo_active_ff;
      wo_start_in      = wo_start_ff;
      intr_cnt_in      = intr_cnt_ff;
      blades_in        = blades_ff;
      permit_in        = permit_ff;

      // whipover window
      if (wo_active_ff) begin
         blades_in = lines.blade;
         if (!lines.blade && blades_ff && (intr_cnt_ff != stlw_pkg::COUNT_MAX)) begin
            intr_cnt_in = intr_cnt_ff + 8'd1;
         end
         if (wo_elapsed >= {{(stlw_pkg::TIME_W-stlw_pkg::WINDOW_W){1'b0}}, cfg.wo_bar_us}) begin
            permit_in = 1'b0;
         end
         if (intr_cnt_in > cfg.max_intr) begin
            permit_in = 1'b1;
         end
         if (wo_elapsed >= {{(stlw_pkg::TIME_W-stlw_pkg::WINDOW_W){1'b0}}, cfg.wo_tmo_us}) begin
            wo_active_in = 1'b0;
            permit_in    = 1'b1;
         end
      end else begin
         if (lines.blade) begin
            wo_active_in = 1'b1;
            wo_start_in  = now;
            intr_cnt_in  = '0;
            blades_in    = 1'b1;
         end
         permit_in = 1'b1;
      end

      // depress qualification
      if (!touch_ff) begin
         if (lines.target) begin
            if (held_ff) begin
               if (press_elapsed >=
                   {{(stlw_pkg::TIME_W-stlw_pkg::WINDOW_W){1'b0}}, cfg.depress_us}) begin
                  touch_in = 1'b1;
               end
            end else if (permit_in) begin
               depress_start_in = now;
               held_in          = 1'b1;
            end
         end else if (held_ff) begin
            depress_start_in = '0;
            held_in          = 1'b0;
         end
      end
   end

   assign self_in = lines.self_touch;

   always_ff @(posedge clock) begin
      if (reset || clear_en) begin
         touch_ff         <= 1'b0;
         depress_start_ff <= '0;
         held_ff          <= 1'b0;
         wo_active_ff     <= 1'b0;
         wo_start_ff      <= '0;
         intr_cnt_ff      <= '0;
         blades_ff        <= 1'b0;
         permit_ff        <= 1'b1;
         self_ff          <= 1'b0;
      end else if (sample_en) begin
         touch_ff         <= touch_in;
         depress_start_ff <= depress_start_in;
         held_ff          <= held_in;
         wo_active_ff     <= wo_active_in;
         wo_start_ff      <= wo_start_in;
         intr_cnt_ff      <= intr_cnt_in;
         blades_ff        <= blades_in;
         permit_ff        <= permit_in;
         self_ff          <= self_in;
      end
   end

   assign status.lock_req = touch_ff &&
      (press_elapsed >= {{(stlw_pkg::TIME_W-stlw_pkg::LOCKOUT_W){1'b0}}, cfg.lockout_us});
   assign status.touch_cur    = touch_ff;
   assign status.scored       = touch_in;
   assign status.self_level   = self_in;
   assign status.self_changed = self_in ^ self_ff;

endmodule

@@ rtl/core/saber_touch_lockout_whipover_core.sv @@
// Top level of the saber touch core: word registers, config registers, lockout, two fencers.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  kind, sample_time_us, a_/b_ line flags
// rsp      out        rsp_valid/rsp_stall  locked_out, scored, self level/changed
// csr      in         csr_write_en         csr_index, csr_data (no read-back)
//
// One word per cycle sustained while rsp is not stalled; a word passes through the input
// register, then the result register, before it shows on rsp. All per-sample work is
// a few 32-bit subtract/compares per fencer between those two registers.
// Reset (synchronous) empties both registers, restores config defaults and
// clears scoring state. req_stall rises only when both registers are full and
// rsp is stalled.

module saber_touch_lockout_whipover_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_kind,
   input  logic [31:0]                          req_sample_time_us,
   input  logic                                 req_a_blade_contact,
   input  logic                                 req_a_on_target,
   input  logic                                 req_a_self_touch,
   input  logic                                 req_b_blade_contact,
   input  logic                                 req_b_on_target,
   input  logic                                 req_b_self_touch,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_locked_out,
   output logic                                 rsp_a_scored,
   output logic                                 rsp_b_scored,
   output logic                                 rsp_a_self_level,
   output logic                                 rsp_b_self_level,
   output logic                                 rsp_a_self_changed,
   output logic                                 rsp_b_self_changed,

   input  logic                                 csr_write_en,
   input  logic [stlw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [stlw_pkg::CSR_DAT_W-1:0]       csr_data
);

   // config registers
   stlw_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_us <= stlw_pkg::LOCKOUT_US_RST;
         cfg_ff.depress_us <= stlw_pkg::DEPRESS_US_RST;
         cfg_ff.wo_bar_us  <= stlw_pkg::WO_BAR_US_RST;
         cfg_ff.wo_tmo_us  <= stlw_pkg::WO_TMO_US_RST;
         cfg_ff.max_intr   <= stlw_pkg::MAX_INTR_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            stlw_pkg::CSR_LOCKOUT_US: cfg_ff.lockout_us <= csr_data;
            stlw_pkg::CSR_DEPRESS_US: cfg_ff.depress_us <= csr_data[stlw_pkg::WINDOW_W-1:0];
            stlw_pkg::CSR_WO_BAR_US:  cfg_ff.wo_bar_us  <= csr_data[stlw_pkg::WINDOW_W-1:0];
            stlw_pkg::CSR_WO_TMO_US:  cfg_ff.wo_tmo_us  <= csr_data[stlw_pkg::WINDOW_W-1:0];
            stlw_pkg::CSR_MAX_INTR:   cfg_ff.max_intr   <= csr_data[stlw_pkg::COUNT_W-1:0];
            default: ;  // unknown index: dropped
         endcase
      end
   end

   // input word register
   logic                          in_valid_ff, in_valid_in;
   logic                          kind_ff;
   logic [stlw_pkg::TIME_W-1:0]   now_ff;
   stlw_pkg::lines_type           a_lines_ff, b_lines_ff;
   logic                          advance;
   logic                          req_take;
   logic                          rsp_valid_ff, rsp_valid_in;

   // result advances when the result register is empty or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff           <= req_kind;
         now_ff            <= req_sample_time_us;
         a_lines_ff        <= '{req_a_blade_contact, req_a_on_target, req_a_self_touch};
         b_lines_ff        <= '{req_b_blade_contact, req_b_on_target, req_b_self_touch};
      end
   end

   // scoring
   logic sample_en, clear_en;
   stlw_pkg::fencer_status_type a_stat, b_stat;

   assign sample_en = advance && (kind_ff == stlw_pkg::KIND_SAMPLE);
   assign clear_en  = advance && (kind_ff == stlw_pkg::KIND_CLEAR);

   stlw_fencer u_fencer_a (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .clear_en  (clear_en),
      .now       (now_ff),
      .lines     (a_lines_ff),
      .cfg       (cfg_ff),
      .status    (a_stat)
   );

   stlw_fencer u_fencer_b (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .clear_en  (clear_en),
      .now       (now_ff),
      .lines     (b_lines_ff),
      .cfg       (cfg_ff),
      .status    (b_stat)
   );

   // lockout looks at touch state from before this sample's update
   logic lockout_ff, lockout_in;

   assign lockout_in = lockout_ff || a_stat.lock_req || b_stat.lock_req ||
                       (a_stat.touch_cur && b_stat.touch_cur);

   always_ff @(posedge clock) begin
      if (reset || clear_en) begin
         lockout_ff <= 1'b0;
      end else if (sample_en) begin
         lockout_ff <= lockout_in;
      end
   end

   // result register
   logic locked_ff, a_scored_ff, b_scored_ff;
   logic a_level_ff, b_level_ff, a_chg_ff, b_chg_ff;

   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // a clear word answers with all zeros
         locked_ff   <= sample_en && lockout_in;
         a_scored_ff <= sample_en && a_stat.scored;
         b_scored_ff <= sample_en && b_stat.scored;
         a_level_ff  <= sample_en && a_stat.self_level;
         b_level_ff  <= sample_en && b_stat.self_level;
         a_chg_ff    <= sample_en && a_stat.self_changed;
         b_chg_ff    <= sample_en && b_stat.self_changed;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_locked_out     = locked_ff;
   assign rsp_a_scored       = a_scored_ff;
   assign rsp_b_scored       = b_scored_ff;
   assign rsp_a_self_level   = a_level_ff;
   assign rsp_b_self_level   = b_level_ff;
   assign rsp_a_self_changed = a_chg_ff;
   assign rsp_b_self_changed = b_chg_ff;

   // lockout only drops through reset or a clear word
   assert property (@(posedge clock) disable iff (reset)
      $fell(lockout_ff) |-> ($past(reset) || $past(clear_en)))
      else $error("lockout dropped without clear");

   // input side stalls only behind a full, stalled result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("req stalled without back-pressure");

   // a clear word yields an all-zero result
   assert property (@(posedge clock) disable iff (reset)
      clear_en |=> (rsp_valid && !rsp_locked_out && !rsp_a_scored && !rsp_b_scored &&
                    !rsp_a_self_level && !rsp_b_self_level &&
                    !rsp_a_self_changed && !rsp_b_self_changed))
      else $error("clear word gave nonzero result");

endmodule
